// ===== rtl/hrrn_pkg.sv =====
// ----------------------------------------------------------------------------
// hrrn_pkg
// Shared types and constants of the response-ratio scheduler.
// ----------------------------------------------------------------------------
package hrrn_pkg;

  // Number of ready-table slots, one cell each.
  localparam int READY_SLOTS = 16;
  localparam int IDX_W       = (READY_SLOTS > 1) ? $clog2(READY_SLOTS) : 1;

  // Request codes.
  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Register byte address of time_limit.
  localparam logic [2:0] ADDR_TIME_LIMIT = 3'd0;

  // Contents of one ready-table slot.
  typedef struct packed {
    logic        valid;
    logic [5:0]  job;
    logic [7:0]  svc;
    logic [15:0] waitc;
  } slot_t;

  // Per-cell update controls for the scan and commit steps.
  typedef struct packed {
    logic        shift;
    logic        wr;
    logic        clr;
    logic        inc;
    logic [5:0]  job;
    logic [7:0]  svc;
  } cell_ctl_t;

endpackage

// ===== rtl/hrrn_if.sv =====
// ----------------------------------------------------------------------------
// hrrn_in_if / hrrn_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface hrrn_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [5:0] job_id;
  logic [7:0] svc_units;
  modport source (output valid, req_type, job_id, svc_units, input ready);
  modport sink   (input valid, req_type, job_id, svc_units, output ready);
endinterface

interface hrrn_out_if;
  logic        valid;
  logic        ready;
  logic        dropped;
  logic        ran_valid;
  logic [5:0]  ran_id;
  logic        finished;
  logic [15:0] step_time;
  modport source (output valid, dropped, ran_valid, ran_id, finished, step_time,
                  input ready);
  modport sink   (input valid, dropped, ran_valid, ran_id, finished, step_time,
                  output ready);
endinterface

// ===== rtl/hrrn_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// hrrn_scheduler_top
// Non-preemptive highest-response-ratio-next scheduler.
// ----------------------------------------------------------------------------
// Requests enter on in_ch: an arrive item places a job in the ready table, a
// tick item runs one unit of time. Every request gives exactly one result
// item on out_ch. The register time_limit sits on the APB-style cfg_ port.
// The ready table is a ring of READY_SLOTS cells that rotates by one cell per
// cycle during a scan, so the head cell presents each slot in turn to one
// compare unit (duplicate and free-slot search, and the ratio compare).
// A tick at or past the limit skips the scan and goes straight to commit.
// One item is in work at a time; the next one is accepted once the current
// result is in the output register, so the output wait overlaps the next item.
// If the receiver stalls, the finished item holds in the output register and
// the following item waits at its commit step until the register frees.
// Reset clears the table, the running job, the time and the output valid;
// time_limit returns to 65535.
// ----------------------------------------------------------------------------
module hrrn_scheduler_top (
  input  logic              clk,
  input  logic              rst_n,
  hrrn_in_if.sink           in_ch,
  hrrn_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int N = hrrn_pkg::READY_SLOTS;
  localparam int W = hrrn_pkg::IDX_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT} state_t;

  state_t      state_r;
  logic [15:0] limit_r;
  logic [15:0] now_r;
  logic        busy_r;
  logic [5:0]  cur_job_r;
  logic [7:0]  cur_left_r;
  logic [W-1:0] cnt_r;

  logic        req_r;
  logic [5:0]  id_r;
  logic [7:0]  svc_r;
  logic        skip_r;

  logic        dup_r, free_found_r;
  logic [W-1:0] free_idx_r;
  logic        best_found_r;
  logic [W-1:0] best_idx_r;
  logic [5:0]  best_job_r;
  logic [7:0]  best_svc_r;
  logic [15:0] best_wait_r;

  logic        o_valid_r, o_dropped_r, o_ran_r, o_fin_r;
  logic [5:0]  o_id_r;
  logic [15:0] o_time_r;

  hrrn_pkg::slot_t     slot_q [N];
  hrrn_pkg::cell_ctl_t ctl    [N];

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == hrrn_pkg::ADDR_TIME_LIMIT) ? {16'd0, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 16'hFFFF;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr == hrrn_pkg::ADDR_TIME_LIMIT)) begin
      limit_r <= cfg_pwdata[15:0];
    end
  end

  // Ratio compare of the head slot against the best so far.
  hrrn_pkg::slot_t head;
  logic [24:0] lhs, rhs;
  logic        cand_better;
  assign head = slot_q[0];
  assign lhs  = (25'(head.waitc) + 25'(head.svc)) * 25'(best_svc_r);
  assign rhs  = (25'(best_wait_r) + 25'(best_svc_r)) * 25'(head.svc);
  assign cand_better = head.valid && (!best_found_r || (lhs > rhs));

  // Commit decisions.
  logic        out_free;
  logic        commit;
  logic        run_eff;
  logic [5:0]  run_job;
  logic [7:0]  run_left;
  logic [7:0]  left_nxt;
  logic        do_write;
  assign out_free = !o_valid_r || out_ch.ready;
  assign commit   = (state_r == S_COMMIT) && out_free;
  assign run_eff  = busy_r || best_found_r;
  assign run_job  = busy_r ? cur_job_r : best_job_r;
  assign run_left = busy_r ? cur_left_r : best_svc_r;
  assign left_nxt = run_left - 8'd1;
  assign do_write = !dup_r && !(busy_r && (cur_job_r == id_r)) && free_found_r;

  // Cell ring: cell i takes its neighbor's contents while scanning.
  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int NX = (i + 1) % N;
    always_comb begin
      ctl[i].shift = (state_r == S_SCAN);
      ctl[i].wr    = commit && (req_r == hrrn_pkg::REQ_ARRIVE) && do_write &&
                     (free_idx_r == W'(i));
      ctl[i].clr   = commit && (req_r == hrrn_pkg::REQ_TICK) && !skip_r && !busy_r &&
                     best_found_r && (best_idx_r == W'(i));
      ctl[i].inc   = commit && (req_r == hrrn_pkg::REQ_TICK) && !skip_r && run_eff;
      ctl[i].job   = id_r;
      ctl[i].svc   = svc_r;
    end
    hrrn_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl[i]),
      .nb   (slot_q[NX]),
      .q    (slot_q[i])
    );
  end

  // Sequencer: accept, scan the ring once (not for a tick at the limit), commit the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      now_r      <= 16'd0;
      busy_r     <= 1'b0;
      cur_job_r  <= 6'd0;
      cur_left_r <= 8'd0;
      o_valid_r  <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (o_valid_r && out_ch.ready && !commit) begin
        o_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            req_r        <= in_ch.req_type;
            id_r         <= in_ch.job_id;
            svc_r        <= (in_ch.svc_units == 8'd0) ? 8'd1 : in_ch.svc_units;
            skip_r       <= (in_ch.req_type == hrrn_pkg::REQ_TICK) && (now_r >= limit_r);
            dup_r        <= 1'b0;
            free_found_r <= 1'b0;
            best_found_r <= 1'b0;
            cnt_r        <= '0;
            if ((in_ch.req_type == hrrn_pkg::REQ_TICK) && (now_r >= limit_r)) begin
              state_r <= S_COMMIT;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (head.valid && (head.job == id_r)) begin
            dup_r <= 1'b1;
          end
          if (!head.valid && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= cnt_r;
          end
          if (cand_better) begin
            best_found_r <= 1'b1;
            best_idx_r   <= cnt_r;
            best_job_r   <= head.job;
            best_svc_r   <= head.svc;
            best_wait_r  <= head.waitc;
          end
          cnt_r <= cnt_r + W'(1);
          if (cnt_r == W'(N - 1)) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            o_valid_r <= 1'b1;
            o_time_r  <= now_r;
            if (req_r == hrrn_pkg::REQ_ARRIVE) begin
              o_dropped_r <= !dup_r && !(busy_r && (cur_job_r == id_r)) && !free_found_r;
              o_ran_r     <= 1'b0;
              o_id_r      <= 6'd0;
              o_fin_r     <= 1'b0;
            end else begin
              o_dropped_r <= 1'b0;
              if (!skip_r) begin
                now_r <= now_r + 16'd1;
              end
              if (!skip_r && run_eff) begin
                o_ran_r    <= 1'b1;
                o_id_r     <= run_job;
                o_fin_r    <= (left_nxt == 8'd0);
                cur_job_r  <= run_job;
                cur_left_r <= left_nxt;
                busy_r     <= (left_nxt != 8'd0);
              end else begin
                o_ran_r <= 1'b0;
                o_id_r  <= 6'd0;
                o_fin_r <= 1'b0;
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = o_valid_r;
  assign out_ch.dropped   = o_dropped_r;
  assign out_ch.ran_valid = o_ran_r;
  assign out_ch.ran_id    = o_id_r;
  assign out_ch.finished  = o_fin_r;
  assign out_ch.step_time = o_time_r;

endmodule

// ===== rtl/hrrn_cell.sv =====
// ----------------------------------------------------------------------------
// hrrn_cell
// One ready-table slot; rotates its contents to the neighbor while scanning.
// ----------------------------------------------------------------------------
module hrrn_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  hrrn_pkg::cell_ctl_t ctl,
  input  hrrn_pkg::slot_t   nb,
  output hrrn_pkg::slot_t   q
);

  logic        valid_r, valid_nxt;
  logic [5:0]  job_r, job_nxt;
  logic [7:0]  svc_r, svc_nxt;
  logic [15:0] wait_r, wait_nxt;

  // Next contents: rotate, load an arrival, remove on dispatch, or age.
  always_comb begin
    valid_nxt = valid_r;
    job_nxt   = job_r;
    svc_nxt   = svc_r;
    wait_nxt  = wait_r;
    if (ctl.shift) begin
      valid_nxt = nb.valid;
      job_nxt   = nb.job;
      svc_nxt   = nb.svc;
      wait_nxt  = nb.waitc;
    end else if (ctl.wr) begin
      valid_nxt = 1'b1;
      job_nxt   = ctl.job;
      svc_nxt   = ctl.svc;
      wait_nxt  = 16'd0;
    end else if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.inc && valid_r && (wait_r != 16'hFFFF)) begin
      wait_nxt = wait_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    job_r  <= job_nxt;
    svc_r  <= svc_nxt;
    wait_r <= wait_nxt;
  end

  assign q = '{valid: valid_r, job: job_r, svc: svc_r, waitc: wait_r};

endmodule
